// ===== hdl/imu_frame_deframer_assert.svh =====
// Assertion macros for the IMU frame deframer.
`ifndef IMU_FRAME_DEFRAMER_ASSERT_SVH
`define IMU_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define IFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("imu_frame_deframer: implication check failed");

// Next-cycle implication.
`define IFD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("imu_frame_deframer: next-cycle check failed");

`endif

// ===== hdl/ifd_pkg.sv =====
// Types and constants shared by the IMU frame deframer.
`timescale 1ns / 1ps
package ifd_pkg;

  localparam int PAYLOAD_DEPTH = 256;
  localparam int PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);

  localparam logic [7:0] ATT_MIN_LEN = 8'd12;
  localparam logic [7:0] POS_MIN_LEN = 8'd16;
  localparam logic [7:0] VEL_MIN_LEN = 8'd12;

  localparam logic [3:0] CFG_PREAMBLE  = 4'd0;
  localparam logic [3:0] CFG_BUS_ID    = 4'd1;
  localparam logic [3:0] CFG_DATA_MID  = 4'd2;
  localparam logic [3:0] CFG_WAKE_MID  = 4'd3;
  localparam logic [3:0] CFG_ERR_MID   = 4'd4;
  localparam logic [3:0] CFG_ATT_ID    = 4'd5;
  localparam logic [3:0] CFG_POS_ID    = 4'd6;
  localparam logic [3:0] CFG_VEL_ID    = 4'd7;

  localparam logic [7:0]  RST_PREAMBLE = 8'hFA;
  localparam logic [7:0]  RST_BUS_ID   = 8'hFF;
  localparam logic [7:0]  RST_DATA_MID = 8'h36;
  localparam logic [7:0]  RST_WAKE_MID = 8'h3E;
  localparam logic [7:0]  RST_ERR_MID  = 8'h42;
  localparam logic [15:0] RST_ATT_ID   = 16'h2030;
  localparam logic [15:0] RST_POS_ID   = 16'h5040;
  localparam logic [15:0] RST_VEL_ID   = 16'hD010;

  localparam logic [1:0] QTY_ATT = 2'd0;
  localparam logic [1:0] QTY_POS = 2'd1;
  localparam logic [1:0] QTY_VEL = 2'd2;

  typedef enum logic [2:0] {
    EV_VALUE = 3'd0,
    EV_DONE  = 3'd1,
    EV_WAKE  = 3'd2,
    EV_ERROR = 3'd3,
    EV_OTHER = 3'd4,
    EV_CKSUM = 3'd5
  } event_e;

  typedef enum logic [3:0] {
    ST_PRE,
    ST_BID,
    ST_MID,
    ST_LEN,
    ST_DATA,
    ST_CHK,
    ST_WK_HDR,
    ST_WK_RD,
    ST_WK_ENTRY,
    ST_WK_WORD,
    ST_WK_EMIT,
    ST_WK_DONE
  } state_e;

endpackage

// ===== hdl/ifd_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ifd_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/imu_frame_deframer.sv =====
// Top level of the IMU frame deframer: byte parser, payload RAM and entry walker.
// Receiving: one byte per cycle unless stalled. A status result is in the output
// register in the cycle after the checksum byte, which stalls while a word still waits.
// A good data frame walks the payload RAM (registered read): a three-byte header per entry,
// size bytes per value word (size 4 or 8) and a done event; it waits on output stalls.
// Bytes are stalled during the walk. Reset: hunt for preamble, registers at defaults.
`timescale 1ns / 1ps
`include "imu_frame_deframer_assert.svh"
module imu_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [1:0]  quantity_o,
  output logic [1:0]  word_index_o,
  output logic [63:0] value_word_o,
  output logic [7:0]  device_error_code_o,
  output logic [7:0]  frame_message_id_o,
  output logic        request_measure_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int AW = ifd_pkg::PAYLOAD_AW;

  ifd_pkg::state_e state_q, state_d;

  logic [7:0]  preamble_q, bus_id_q, data_mid_q, wake_mid_q, err_mid_q;
  logic [15:0] att_id_q, pos_id_q, vel_id_q;

  logic [7:0]  sum_q, sum_d;
  logic [7:0]  mid_q, mid_d;
  logic [7:0]  plen_q, plen_d;
  logic [8:0]  bcnt_q, bcnt_d;
  logic [7:0]  first_q, first_d;

  logic [8:0]  pos_q, pos_d;
  logic [8:0]  raddr_q, raddr_d;
  logic [3:0]  issue_q, issue_d;
  logic        rvalid_q, rvalid_d;
  logic        oor_q, oor_d;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  qty_q, qty_d;
  logic [1:0]  nw_q, nw_d;
  logic [3:0]  nb_q, nb_d;
  logic [1:0]  widx_q, widx_d;
  logic        hdr_q, hdr_d;

  logic            out_valid_q, out_valid_d;
  ifd_pkg::event_e ev_q, ev_d;
  logic [1:0]      oqty_q, oqty_d;
  logic [1:0]      owidx_q, owidx_d;
  logic [63:0]     oval_q, oval_d;
  logic [7:0]      ocode_q, ocode_d;
  logic [7:0]      omid_q, omid_d;
  logic            oreq_q, oreq_d;
  logic            olast_q, olast_d;

  logic        in_acc, out_free, walking;
  logic        ram_we, ram_re;
  logic [7:0]  ram_rdata;
  logic [7:0]  sum_new;
  logic [8:0]  bcnt_inc;
  logic [15:0] ent_id;
  logic [7:0]  ent_len;
  logic [9:0]  ent_end;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q <= ifd_pkg::RST_PREAMBLE;
      bus_id_q   <= ifd_pkg::RST_BUS_ID;
      data_mid_q <= ifd_pkg::RST_DATA_MID;
      wake_mid_q <= ifd_pkg::RST_WAKE_MID;
      err_mid_q  <= ifd_pkg::RST_ERR_MID;
      att_id_q   <= ifd_pkg::RST_ATT_ID;
      pos_id_q   <= ifd_pkg::RST_POS_ID;
      vel_id_q   <= ifd_pkg::RST_VEL_ID;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ifd_pkg::CFG_PREAMBLE: preamble_q <= cfg_wdata_i[7:0];
        ifd_pkg::CFG_BUS_ID:   bus_id_q   <= cfg_wdata_i[7:0];
        ifd_pkg::CFG_DATA_MID: data_mid_q <= cfg_wdata_i[7:0];
        ifd_pkg::CFG_WAKE_MID: wake_mid_q <= cfg_wdata_i[7:0];
        ifd_pkg::CFG_ERR_MID:  err_mid_q  <= cfg_wdata_i[7:0];
        ifd_pkg::CFG_ATT_ID:   att_id_q   <= cfg_wdata_i;
        ifd_pkg::CFG_POS_ID:   pos_id_q   <= cfg_wdata_i;
        ifd_pkg::CFG_VEL_ID:   vel_id_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign walking  = (state_q == ifd_pkg::ST_WK_HDR) || (state_q == ifd_pkg::ST_WK_RD) ||
                    (state_q == ifd_pkg::ST_WK_ENTRY) || (state_q == ifd_pkg::ST_WK_WORD) ||
                    (state_q == ifd_pkg::ST_WK_EMIT) || (state_q == ifd_pkg::ST_WK_DONE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = walking || ((state_q == ifd_pkg::ST_CHK) && !out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign sum_new  = sum_q + rx_byte_i;
  assign bcnt_inc = bcnt_q + 9'd1;
  assign ent_id   = acc_q[23:8];
  assign ent_len  = acc_q[7:0];
  assign ent_end  = {1'b0, pos_q} + 10'd3 + {2'b00, ent_len};

  assign ram_we = in_acc && (state_q == ifd_pkg::ST_DATA) &&
                  (bcnt_q < 9'(ifd_pkg::PAYLOAD_DEPTH));
  assign ram_re = (state_q == ifd_pkg::ST_WK_RD) && (issue_q != 4'd0);

  ifd_ram #(
    .Width(8),
    .Depth(ifd_pkg::PAYLOAD_DEPTH)
  ) u_payload_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(bcnt_q[AW-1:0]),
    .wdata_i(rx_byte_i),
    .re_i   (ram_re),
    .raddr_i(raddr_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d  = state_q;
    sum_d    = sum_q;
    mid_d    = mid_q;
    plen_d   = plen_q;
    bcnt_d   = bcnt_q;
    first_d  = first_q;
    pos_d    = pos_q;
    raddr_d  = raddr_q;
    issue_d  = issue_q;
    rvalid_d = ram_re;
    oor_d    = raddr_q >= 9'(ifd_pkg::PAYLOAD_DEPTH);
    acc_d    = acc_q;
    qty_d    = qty_q;
    nw_d     = nw_q;
    nb_d     = nb_q;
    widx_d   = widx_q;
    hdr_d    = hdr_q;

    out_valid_d = out_valid_q && out_stall_i;
    ev_d    = ev_q;
    oqty_d  = oqty_q;
    owidx_d = owidx_q;
    oval_d  = oval_q;
    ocode_d = ocode_q;
    omid_d  = omid_q;
    oreq_d  = oreq_q;
    olast_d = olast_q;

    unique case (state_q)
      ifd_pkg::ST_PRE: begin
        if (in_acc && (rx_byte_i == preamble_q)) begin
          state_d = ifd_pkg::ST_BID;
        end
      end
      ifd_pkg::ST_BID: begin
        if (in_acc) begin
          if (rx_byte_i == bus_id_q) begin
            sum_d   = rx_byte_i;
            state_d = ifd_pkg::ST_MID;
          end else begin
            state_d = ifd_pkg::ST_PRE;
          end
        end
      end
      ifd_pkg::ST_MID: begin
        if (in_acc) begin
          mid_d   = rx_byte_i;
          sum_d   = sum_new;
          state_d = ifd_pkg::ST_LEN;
        end
      end
      ifd_pkg::ST_LEN: begin
        if (in_acc) begin
          plen_d  = rx_byte_i;
          bcnt_d  = 9'd0;
          sum_d   = sum_new;
          state_d = (rx_byte_i != 8'd0) ? ifd_pkg::ST_DATA : ifd_pkg::ST_CHK;
        end
      end
      ifd_pkg::ST_DATA: begin
        if (in_acc) begin
          if (bcnt_q == 9'd0) begin
            first_d = rx_byte_i;
          end
          bcnt_d = bcnt_inc;
          sum_d  = sum_new;
          if (bcnt_inc >= {1'b0, plen_q}) begin
            state_d = ifd_pkg::ST_CHK;
          end
        end
      end
      ifd_pkg::ST_CHK: begin
        if (in_acc) begin
          sum_d   = sum_new;
          state_d = ifd_pkg::ST_PRE;
          ev_d    = ifd_pkg::EV_OTHER;
          oqty_d  = 2'd0;
          owidx_d = 2'd0;
          oval_d  = 64'd0;
          ocode_d = 8'd0;
          omid_d  = mid_q;
          oreq_d  = 1'b0;
          olast_d = 1'b1;
          out_valid_d = 1'b1;
          priority if (sum_new != 8'd0) begin
            ev_d = ifd_pkg::EV_CKSUM;
          end else if (mid_q == wake_mid_q) begin
            ev_d   = ifd_pkg::EV_WAKE;
            oreq_d = 1'b1;
          end else if (mid_q == data_mid_q) begin
            out_valid_d = out_valid_q && out_stall_i;
            pos_d   = 9'd0;
            state_d = ifd_pkg::ST_WK_HDR;
          end else if (mid_q == err_mid_q) begin
            ev_d    = ifd_pkg::EV_ERROR;
            ocode_d = (plen_q != 8'd0) ? first_q : 8'd0;
          end else begin
            oreq_d = 1'b1;
          end
        end
      end
      ifd_pkg::ST_WK_HDR: begin
        if ((pos_q + 9'd2) < {1'b0, plen_q}) begin
          acc_d   = 64'd0;
          raddr_d = pos_q;
          issue_d = 4'd3;
          hdr_d   = 1'b1;
          state_d = ifd_pkg::ST_WK_RD;
        end else begin
          state_d = ifd_pkg::ST_WK_DONE;
        end
      end
      ifd_pkg::ST_WK_RD: begin
        if (ram_re) begin
          raddr_d = raddr_q + 9'd1;
          issue_d = issue_q - 4'd1;
        end
        if (rvalid_q) begin
          acc_d = {acc_q[55:0], oor_q ? 8'd0 : ram_rdata};
          if (issue_q == 4'd0) begin
            state_d = hdr_q ? ifd_pkg::ST_WK_ENTRY : ifd_pkg::ST_WK_EMIT;
          end
        end
      end
      ifd_pkg::ST_WK_ENTRY: begin
        raddr_d = pos_q + 9'd3;
        widx_d  = 2'd0;
        if (ent_end > {2'b00, plen_q}) begin
          state_d = ifd_pkg::ST_WK_DONE;
        end else begin
          pos_d   = ent_end[8:0];
          state_d = ifd_pkg::ST_WK_HDR;
          priority if (ent_id == att_id_q) begin
            if (ent_len >= ifd_pkg::ATT_MIN_LEN) begin
              qty_d   = ifd_pkg::QTY_ATT;
              nw_d    = 2'd3;
              nb_d    = 4'd4;
              state_d = ifd_pkg::ST_WK_WORD;
            end
          end else if (ent_id == pos_id_q) begin
            if (ent_len >= ifd_pkg::POS_MIN_LEN) begin
              qty_d   = ifd_pkg::QTY_POS;
              nw_d    = 2'd2;
              nb_d    = 4'd8;
              state_d = ifd_pkg::ST_WK_WORD;
            end
          end else if (ent_id == vel_id_q) begin
            if (ent_len >= ifd_pkg::VEL_MIN_LEN) begin
              qty_d   = ifd_pkg::QTY_VEL;
              nw_d    = 2'd3;
              nb_d    = 4'd4;
              state_d = ifd_pkg::ST_WK_WORD;
            end
          end else begin
            state_d = ifd_pkg::ST_WK_HDR;
          end
        end
      end
      ifd_pkg::ST_WK_WORD: begin
        acc_d   = 64'd0;
        issue_d = nb_q;
        hdr_d   = 1'b0;
        state_d = ifd_pkg::ST_WK_RD;
      end
      ifd_pkg::ST_WK_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ev_d    = ifd_pkg::EV_VALUE;
          oqty_d  = qty_q;
          owidx_d = widx_q;
          oval_d  = acc_q;
          ocode_d = 8'd0;
          omid_d  = mid_q;
          oreq_d  = 1'b0;
          olast_d = 1'b0;
          if (widx_q == (nw_q - 2'd1)) begin
            state_d = ifd_pkg::ST_WK_HDR;
          end else begin
            widx_d  = widx_q + 2'd1;
            state_d = ifd_pkg::ST_WK_WORD;
          end
        end
      end
      ifd_pkg::ST_WK_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ev_d    = ifd_pkg::EV_DONE;
          oqty_d  = 2'd0;
          owidx_d = 2'd0;
          oval_d  = 64'd0;
          ocode_d = 8'd0;
          omid_d  = mid_q;
          oreq_d  = 1'b0;
          olast_d = 1'b1;
          state_d = ifd_pkg::ST_PRE;
        end
      end
      default: begin
        state_d = ifd_pkg::ST_PRE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ifd_pkg::ST_PRE;
      sum_q       <= 8'd0;
      mid_q       <= 8'd0;
      plen_q      <= 8'd0;
      bcnt_q      <= 9'd0;
      issue_q     <= 4'd0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      mid_q       <= mid_d;
      plen_q      <= plen_d;
      bcnt_q      <= bcnt_d;
      issue_q     <= issue_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    pos_q   <= pos_d;
    raddr_q <= raddr_d;
    oor_q   <= oor_d;
    acc_q   <= acc_d;
    qty_q   <= qty_d;
    nw_q    <= nw_d;
    nb_q    <= nb_d;
    widx_q  <= widx_d;
    hdr_q   <= hdr_d;
    ev_q    <= ev_d;
    oqty_q  <= oqty_d;
    owidx_q <= owidx_d;
    oval_q  <= oval_d;
    ocode_q <= ocode_d;
    omid_q  <= omid_d;
    oreq_q  <= oreq_d;
    olast_q <= olast_d;
  end

  assign out_valid_o         = out_valid_q;
  assign event_res_o         = ev_q;
  assign quantity_o          = oqty_q;
  assign word_index_o        = owidx_q;
  assign value_word_o        = oval_q;
  assign device_error_code_o = ocode_q;
  assign frame_message_id_o  = omid_q;
  assign request_measure_o   = oreq_q;
  assign last_o              = olast_q;

  `IFD_ASSERT_IMP(a_done_is_last, out_valid_o && (event_res_o == ifd_pkg::EV_DONE), last_o)
  `IFD_ASSERT_IMP(a_value_not_last, out_valid_o && (event_res_o == ifd_pkg::EV_VALUE), !last_o)
  `IFD_ASSERT_IMP(a_ram_port_excl, ram_we, !ram_re)
  `IFD_ASSERT_NXT(a_done_to_hunt, (state_q == ifd_pkg::ST_WK_DONE) && out_free,
                  (state_q == ifd_pkg::ST_PRE) && out_valid_o && last_o)

endmodule
